// ----- hw/rtl/scsc_pkg.sv -----
// Shared types, result codes, character codes and range tables of the servo slew controller.
package scsc_pkg;

  localparam int MAX_CH = 8;

  localparam logic [2:0] RC_OK      = 3'd0;
  localparam logic [2:0] RC_RANGE   = 3'd1;
  localparam logic [2:0] RC_UNKNOWN = 3'd2;
  localparam logic [2:0] RC_HELP    = 3'd3;
  localparam logic [2:0] RC_STATUS  = 3'd4;
  localparam logic [2:0] RC_STEP    = 3'd5;
  localparam logic [2:0] RC_DONE    = 3'd6;
  localparam logic [2:0] RC_READY   = 3'd7;

  localparam logic       REG_STEP_INTERVAL   = 1'b0;
  localparam logic [9:0] STEP_INTERVAL_RESET = 10'd20;

  localparam logic [9:0]  NUM_CAP  = 10'd1023;
  localparam logic [9:0]  STEP_CAP = 10'd1023;
  localparam logic [12:0] IDLE_CAP = 13'd8191;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_G     = 8'h47;
  localparam logic [7:0] CHAR_H     = 8'h48;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
  localparam logic [7:0] CASE_SHIFT = 8'h20;

  typedef struct packed {
    logic       req_type;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0] result_code;
    logic [2:0] servo_id;
    logic [7:0] angle;
    logic [7:0] range_min;
    logic [7:0] range_max;
    logic [9:0] speed_report;
    logic       last;
  } out_item_t;

  // Describes every result one item causes: either a list over all servos,
  // or an optional single result followed by an optional ready hint.
  typedef struct packed {
    logic                   is_list;
    logic [2:0]             list_code;
    logic                   has_a;
    logic [2:0]             a_code;
    logic [2:0]             a_id;
    logic [7:0]             a_angle;
    logic                   has_ready;
    logic [MAX_CH-1:0][7:0] angles;
    logic [9:0]             speed;
  } desc_t;

  function automatic logic [7:0] range_lo(input logic [2:0] id);
    logic [7:0] r;
    case (id)
      3'd1:    r = 8'd45;
      3'd3:    r = 8'd90;
      3'd5:    r = 8'd90;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] range_hi(input logic [2:0] id);
    logic [7:0] r;
    case (id)
      3'd1:    r = 8'd90;
      3'd2:    r = 8'd85;
      default: r = 8'd180;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/scsc_core.sv -----
// Input register, line parser and servo slew state; produces at most one result descriptor per item.
module scsc_core import scsc_pkg::*; #(
  parameter int NUM_CHANNELS = 6,
  parameter int LINE_LIMIT   = 31,
  parameter int READY_PERIOD = 5000
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  in_item_t   req,
  input  logic [9:0] step_interval,
  output logic       desc_valid,
  input  logic       desc_ready,
  output desc_t      desc
);

  localparam int CC_W = $clog2(LINE_LIMIT + 1);
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam logic [1:0] PH_SKIP   = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_END    = 2'd3;

  logic            s1_valid;
  in_item_t        s1;
  logic            go;

  logic [7:0]      first_char, first_char_next;
  logic [CC_W-1:0] char_count, char_count_next;
  logic [9:0]      num_value, num_value_next;
  logic [1:0]      num_phase, num_phase_next;
  logic            num_negative, num_negative_next;
  logic            nul_second, nul_second_next;
  logic [7:0]      current_angle [NUM_CHANNELS];
  logic [7:0]      current_angle_next [NUM_CHANNELS];
  logic [7:0]      target_angle [NUM_CHANNELS];
  logic [7:0]      target_angle_next [NUM_CHANNELS];
  logic            active_valid, active_valid_next;
  logic [2:0]      active_index, active_index_next;
  logic [9:0]      step_elapsed, step_elapsed_next;
  logic [12:0]     idle_elapsed, idle_elapsed_next;

  assign go        = s1_valid && desc_ready;
  assign req_stall = s1_valid && !desc_ready;

  always_comb begin
    logic [7:0]  c;
    logic [7:0]  upper;
    logic [7:0]  sid_full;
    logic [2:0]  sid;
    logic        found;
    logic        num_ok;
    logic        digit;
    logic [13:0] num_mac;
    logic [9:0]  num_sat;
    logic [9:0]  step_inc;
    logic [12:0] idle_inc;
    logic [7:0]  cur_a;
    logic [7:0]  tgt_a;
    logic [7:0]  new_a;
    logic        act_after;

    first_char_next    = first_char;
    char_count_next    = char_count;
    num_value_next     = num_value;
    num_phase_next     = num_phase;
    num_negative_next  = num_negative;
    nul_second_next    = nul_second;
    current_angle_next = current_angle;
    target_angle_next  = target_angle;
    active_valid_next  = active_valid;
    active_index_next  = active_index;
    step_elapsed_next  = step_elapsed;
    idle_elapsed_next  = idle_elapsed;

    desc = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      desc.angles[i] = current_angle[i];
    end
    desc.speed = step_interval;

    c     = s1.byte_value;
    upper = (first_char >= CHAR_LC_A && first_char <= CHAR_LC_Z) ?
            first_char - CASE_SHIFT : first_char;
    sid_full = upper - CHAR_A;
    found    = (upper >= CHAR_A) && (sid_full < 8'(NUM_CHANNELS));
    sid      = sid_full[2:0];
    num_ok   = (!num_negative || num_value == 10'd0) &&
               num_value >= {2'b00, range_lo(sid)} &&
               num_value <= {2'b00, range_hi(sid)};
    digit    = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    num_mac  = ({4'b0, num_value} << 3) + ({4'b0, num_value} << 1) + {10'b0, c[3:0]};
    num_sat  = (num_mac > {4'b0, NUM_CAP}) ? NUM_CAP : num_mac[9:0];
    step_inc = (step_elapsed == STEP_CAP) ? step_elapsed : step_elapsed + 10'd1;
    idle_inc = (idle_elapsed == IDLE_CAP) ? idle_elapsed : idle_elapsed + 13'd1;
    cur_a    = current_angle[active_index[CH_W-1:0]];
    tgt_a    = target_angle[active_index[CH_W-1:0]];
    new_a    = (cur_a < tgt_a) ? cur_a + 8'd1 : cur_a - 8'd1;
    act_after = active_valid;

    if (go) begin
      if (!s1.req_type) begin
        if (c == CHAR_LF || c == CHAR_CR) begin
          if (char_count != '0) begin
            first_char_next   = '0;
            char_count_next   = '0;
            num_value_next    = '0;
            num_phase_next    = PH_SKIP;
            num_negative_next = 1'b0;
            nul_second_next   = 1'b0;
            idle_elapsed_next = '0;
            if (first_char != CHAR_NUL) begin
              if (upper == CHAR_QMARK || upper == CHAR_H) begin
                desc.is_list   = 1'b1;
                desc.list_code = RC_HELP;
              end else if (upper == CHAR_G) begin
                desc.is_list   = 1'b1;
                desc.list_code = RC_STATUS;
              end else if (found && char_count >= CC_W'(2) && !nul_second) begin
                desc.has_a = 1'b1;
                desc.a_id  = sid;
                if (num_ok) begin
                  desc.a_code  = RC_OK;
                  desc.a_angle = num_value[7:0];
                  target_angle_next[sid[CH_W-1:0]] = num_value[7:0];
                  active_valid_next = 1'b1;
                  active_index_next = sid;
                end else begin
                  desc.a_code = RC_RANGE;
                end
              end else begin
                desc.has_a  = 1'b1;
                desc.a_code = RC_UNKNOWN;
              end
            end
          end
        end else if (char_count < CC_W'(LINE_LIMIT)) begin
          char_count_next = char_count + CC_W'(1);
          if (char_count == '0) begin
            first_char_next = c;
          end else if (c == CHAR_NUL) begin
            if (char_count == CC_W'(1)) begin
              nul_second_next = 1'b1;
            end
            num_phase_next = PH_END;
          end else if (num_phase != PH_END) begin
            if (num_phase == PH_SKIP &&
                (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF)) begin
              num_phase_next = PH_SKIP;
            end else if (num_phase == PH_SKIP && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
              num_negative_next = (c == CHAR_MINUS);
              num_phase_next    = PH_SIGN;
            end else if (digit) begin
              num_value_next = num_sat;
              num_phase_next = PH_DIGITS;
            end else begin
              num_phase_next = PH_END;
            end
          end
        end
      end else begin
        step_elapsed_next = step_inc;
        idle_elapsed_next = idle_inc;
        if (active_valid && step_inc >= step_interval) begin
          step_elapsed_next = '0;
          desc.has_a = 1'b1;
          desc.a_id  = active_index;
          if (cur_a != tgt_a) begin
            current_angle_next[active_index[CH_W-1:0]] = new_a;
            desc.a_code  = RC_STEP;
            desc.a_angle = new_a;
          end else begin
            active_valid_next = 1'b0;
            act_after         = 1'b0;
            desc.a_code       = RC_DONE;
            desc.a_angle      = cur_a;
          end
        end
        if (!act_after && idle_inc > 13'(READY_PERIOD)) begin
          idle_elapsed_next = '0;
          desc.has_ready    = 1'b1;
        end
      end
    end

    desc_valid = desc.is_list || desc.has_a || desc.has_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      first_char   <= '0;
      char_count   <= '0;
      num_value    <= '0;
      num_phase    <= PH_SKIP;
      num_negative <= 1'b0;
      nul_second   <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        current_angle[i] <= range_lo(3'(i));
        target_angle[i]  <= range_lo(3'(i));
      end
      active_valid <= 1'b0;
      active_index <= '0;
      step_elapsed <= '0;
      idle_elapsed <= '0;
    end else begin
      if (req_valid && !req_stall) begin
        s1_valid <= 1'b1;
      end else if (go) begin
        s1_valid <= 1'b0;
      end
      first_char    <= first_char_next;
      char_count    <= char_count_next;
      num_value     <= num_value_next;
      num_phase     <= num_phase_next;
      num_negative  <= num_negative_next;
      nul_second    <= nul_second_next;
      current_angle <= current_angle_next;
      target_angle  <= target_angle_next;
      active_valid  <= active_valid_next;
      active_index  <= active_index_next;
      step_elapsed  <= step_elapsed_next;
      idle_elapsed  <= idle_elapsed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s1 <= req;
    end
  end

  a_line_bound: assert property (@(posedge clk) disable iff (rst)
    char_count <= CC_W'(LINE_LIMIT))
    else $error("Stored line length exceeds its limit.");

  a_active_index: assert property (@(posedge clk) disable iff (rst)
    active_valid |-> {1'b0, active_index} < 4'(NUM_CHANNELS))
    else $error("Active servo index is outside the configured channels.");

endmodule

// ----- hw/rtl/scsc_expand.sv -----
// Descriptor buffer and result sequencer: one result per cycle to the output register unless stalled.
module scsc_expand import scsc_pkg::*; #(
  parameter int NUM_CHANNELS = 6
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      desc_valid,
  output logic      desc_ready,
  input  desc_t     desc,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output out_item_t rsp
);

  localparam logic [2:0] CNT_LAST = 3'(NUM_CHANNELS - 1);

  logic      pend_valid;
  desc_t     pend;
  logic      cur_valid;
  desc_t     cur;
  logic [2:0] cnt;

  logic      emit;
  logic      final_one;
  logic      take_pend;
  out_item_t result;

  always_comb begin
    result = '0;
    if (cur.is_list) begin
      result.result_code = cur.list_code;
      result.servo_id    = cnt;
      if (cur.list_code == RC_STATUS) begin
        result.angle        = cur.angles[cnt];
        result.speed_report = cur.speed;
      end
      final_one = (cnt == CNT_LAST);
    end else if (cnt == 3'd0) begin
      result.result_code = cur.a_code;
      result.servo_id    = cur.a_id;
      result.angle       = cur.a_angle;
      final_one          = !cur.has_ready;
    end else begin
      result.result_code = RC_READY;
      final_one          = 1'b1;
    end
    if (result.result_code != RC_UNKNOWN && result.result_code != RC_READY) begin
      result.range_min = range_lo(result.servo_id);
      result.range_max = range_hi(result.servo_id);
    end
    result.last = final_one;

    emit       = cur_valid && (!rsp_valid || !rsp_stall);
    take_pend  = pend_valid && (!cur_valid || (emit && final_one));
    desc_ready = !pend_valid || take_pend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      cur_valid  <= 1'b0;
      cnt        <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (desc_valid && desc_ready) begin
        pend_valid <= 1'b1;
      end else if (take_pend) begin
        pend_valid <= 1'b0;
      end

      if (take_pend) begin
        cur_valid <= 1'b1;
        cnt       <= (pend.is_list || pend.has_a) ? 3'd0 : 3'd1;
      end else if (emit && final_one) begin
        cur_valid <= 1'b0;
      end else if (emit) begin
        cnt <= cnt + 3'd1;
      end

      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (desc_valid && desc_ready) begin
      pend <= desc;
    end
    if (take_pend) begin
      cur <= pend;
    end
    if (emit) begin
      rsp <= result;
    end
  end

  a_list_count: assert property (@(posedge clk) disable iff (rst)
    cur_valid && cur.is_list |-> cnt <= CNT_LAST)
    else $error("List counter ran past the last servo.");

  a_refill: assert property (@(posedge clk) disable iff (rst)
    pend_valid && !cur_valid |=> cur_valid)
    else $error("Pending descriptor was not moved into the empty sequencer.");

  a_speed_only_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.result_code != RC_STATUS |-> rsp.speed_report == 10'd0)
    else $error("Speed reported on a result other than a status entry.");

endmodule

// ----- hw/rtl/servo_command_slew_controller_top.sv -----
// Top level of the servo command and slew controller with its configuration register port.
//
// Items on the req channel are either received command bytes or one-millisecond
// ticks; results leave on the rsp channel. An item is taken at a clock edge where
// its valid is high and its stall is low. Bytes build a command line that is parsed
// as it arrives and acted on at CR or LF; ticks slew the active servo by one degree
// per step interval and raise a ready hint after a long idle period.
// One item is accepted every cycle as long as rsp_stall is low and each item
// yields at most one result. A help or status line yields one result per servo,
// one per cycle while rsp_stall is low, and the sequencer then holds req_stall
// high until it has room for a further item. The first result of an item passes
// the input, descriptor buffer, sequencer and output registers on its way to rsp.
// When the receiver stalls, the output register holds its item and the stall
// backs up through the descriptor buffer to req_stall.
// Reset clears the line, returns every servo to its range minimum with no servo
// active, clears both millisecond counters and sets the step interval to 20 ms.
// The step interval register sits at byte address 0 of the APB-style port.
module servo_command_slew_controller_top import scsc_pkg::*; #(
  parameter int NUM_CHANNELS = 6,
  parameter int LINE_LIMIT   = 31,
  parameter int READY_PERIOD = 5000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  in_item_t    req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output out_item_t   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [9:0] step_interval;
  logic       desc_valid;
  logic       desc_ready;
  desc_t      desc;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_STEP_INTERVAL) ? {22'b0, step_interval} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_interval <= STEP_INTERVAL_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_STEP_INTERVAL) begin
      step_interval <= pwdata[9:0];
    end
  end

  scsc_core #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .LINE_LIMIT   (LINE_LIMIT),
    .READY_PERIOD (READY_PERIOD)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .req           (req),
    .step_interval (step_interval),
    .desc_valid    (desc_valid),
    .desc_ready    (desc_ready),
    .desc          (desc)
  );

  scsc_expand #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_expand (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (desc_valid),
    .desc_ready (desc_ready),
    .desc       (desc),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule

// ----- sim/tb_servo_command_slew_controller_top.sv -----
// Self-checking testbench of the servo command and slew controller, with a scoreboard class.
`timescale 1ns / 1ps

package servo_tb_pkg;
  import scsc_pkg::*;

  localparam int SERVOS   = 6;
  localparam int LINE_MAX = 31;
  localparam int READY_MS = 5000;
  localparam logic [0:7][7:0] SAFE_MIN = {8'd0, 8'd45, 8'd0, 8'd90, 8'd0, 8'd90, 8'd0, 8'd0};
  localparam logic [0:7][7:0] SAFE_MAX = {8'd180, 8'd90, 8'd85, 8'd180,
                                          8'd180, 8'd180, 8'd180, 8'd180};

  class servo_scoreboard;
    logic [9:0]  interval;
    logic [7:0]  first_ch;
    logic [4:0]  char_cnt;
    logic [9:0]  num_val;
    logic [1:0]  num_ph;
    logic        num_neg;
    logic        nul_at_one;
    logic [7:0]  cur_ang [8];
    logic [7:0]  tgt_ang [8];
    logic        moving;
    logic [2:0]  moving_id;
    logic [9:0]  step_ms;
    logic [12:0] idle_ms;
    out_item_t   fresh [$];
    out_item_t   awaited [$];
    int          errors;
    int          checked;

    function new();
      int i;
      interval = STEP_INTERVAL_RESET;
      clear_line();
      for (i = 0; i < 8; i++) begin
        cur_ang[i] = SAFE_MIN[i];
        tgt_ang[i] = SAFE_MIN[i];
      end
      moving    = 1'b0;
      moving_id = 3'd0;
      step_ms   = '0;
      idle_ms   = '0;
      errors    = 0;
      checked   = 0;
    endfunction

    function void clear_line();
      first_ch   = CHAR_NUL;
      char_cnt   = '0;
      num_val    = '0;
      num_ph     = 2'd0;
      num_neg    = 1'b0;
      nul_at_one = 1'b0;
    endfunction

    function void set_interval(logic [9:0] value);
      interval = value;
    endfunction

    function bit servo_moving();
      return moving;
    endfunction

    function int awaited_count();
      return awaited.size();
    endfunction

    function logic [7:0] angle_of(int id);
      return cur_ang[id];
    endfunction

    function void add_result(logic [2:0] code, logic [2:0] id, logic [7:0] ang,
                             logic [9:0] spd);
      out_item_t r;
      r.result_code  = code;
      r.servo_id     = id;
      r.angle        = ang;
      r.range_min    = (code == RC_UNKNOWN || code == RC_READY) ? 8'd0 : SAFE_MIN[id];
      r.range_max    = (code == RC_UNKNOWN || code == RC_READY) ? 8'd0 : SAFE_MAX[id];
      r.speed_report = spd;
      r.last         = 1'b0;
      fresh.push_back(r);
    endfunction

    function void take_number_char(logic [7:0] c);
      int acc;
      if (num_ph == 2'd0) begin
        if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VT || c == CHAR_FF) return;
        if (c == CHAR_PLUS || c == CHAR_MINUS) begin
          num_neg = (c == CHAR_MINUS);
          num_ph  = 2'd1;
          return;
        end
      end
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        acc     = int'(num_val) * 10 + int'(c - CHAR_ZERO);
        num_val = (acc > int'(NUM_CAP)) ? NUM_CAP : acc[9:0];
        num_ph  = 2'd2;
      end else begin
        num_ph = 2'd3;
      end
    endfunction

    function void finish_line();
      logic [7:0] u;
      int         i;
      int         sel;
      bit         ok;
      u = first_ch;
      if (u == CHAR_NUL) return;
      if (u >= CHAR_LC_A && u <= CHAR_LC_Z) u = u - CASE_SHIFT;
      if (u == CHAR_QMARK || u == CHAR_H) begin
        for (i = 0; i < SERVOS; i++) add_result(RC_HELP, 3'(i), 8'd0, 10'd0);
        return;
      end
      if (u == CHAR_G) begin
        for (i = 0; i < SERVOS; i++) add_result(RC_STATUS, 3'(i), cur_ang[i], interval);
        return;
      end
      sel = SERVOS;
      for (i = 0; i < SERVOS; i++) begin
        if (sel == SERVOS && u == CHAR_A + 8'(i)) sel = i;
      end
      if (sel < SERVOS && char_cnt >= 5'd2 && !nul_at_one) begin
        ok = (!num_neg || num_val == 10'd0) && num_val >= {2'b00, SAFE_MIN[sel]} &&
             num_val <= {2'b00, SAFE_MAX[sel]};
        if (ok) begin
          tgt_ang[sel] = num_val[7:0];
          moving       = 1'b1;
          moving_id    = 3'(sel);
          add_result(RC_OK, 3'(sel), num_val[7:0], 10'd0);
        end else begin
          add_result(RC_RANGE, 3'(sel), 8'd0, 10'd0);
        end
        return;
      end
      add_result(RC_UNKNOWN, 3'd0, 8'd0, 10'd0);
    endfunction

    function void note_input(in_item_t it);
      logic [7:0] c;
      logic [2:0] id;
      out_item_t  r;
      int         k;
      fresh.delete();
      if (it.req_type == 1'b0) begin
        c = it.byte_value;
        if (c == CHAR_LF || c == CHAR_CR) begin
          if (char_cnt != 5'd0) begin
            finish_line();
            clear_line();
            idle_ms = '0;
          end
        end else if (char_cnt < 5'(LINE_MAX)) begin
          if (char_cnt == 5'd0) begin
            first_ch = c;
          end else if (c == CHAR_NUL) begin
            if (char_cnt == 5'd1) nul_at_one = 1'b1;
            num_ph = 2'd3;
          end else if (num_ph != 2'd3) begin
            take_number_char(c);
          end
          char_cnt = char_cnt + 5'd1;
        end
      end else begin
        if (step_ms < STEP_CAP) step_ms = step_ms + 10'd1;
        if (idle_ms < IDLE_CAP) idle_ms = idle_ms + 13'd1;
        if (moving && step_ms >= interval) begin
          id      = moving_id;
          step_ms = '0;
          if (cur_ang[id] != tgt_ang[id]) begin
            if (cur_ang[id] < tgt_ang[id]) cur_ang[id] = cur_ang[id] + 8'd1;
            else cur_ang[id] = cur_ang[id] - 8'd1;
            add_result(RC_STEP, id, cur_ang[id], 10'd0);
          end else begin
            moving = 1'b0;
            add_result(RC_DONE, id, cur_ang[id], 10'd0);
          end
        end
        if (!moving && idle_ms > 13'(READY_MS)) begin
          idle_ms = '0;
          add_result(RC_READY, 3'd0, 8'd0, 10'd0);
        end
      end
      if (fresh.size() > 0) begin
        r = fresh.pop_back();
        r.last = 1'b1;
        fresh.push_back(r);
      end
      for (k = 0; k < fresh.size(); k++) awaited.push_back(fresh[k]);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("mismatch at result %0d: %s", checked, what);
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      checked++;
      if (awaited.size() == 0) begin
        report($sformatf("result %h arrived with nothing outstanding", got));
        return;
      end
      want = awaited.pop_front();
      compare_field("result_code", 32'(got.result_code), 32'(want.result_code));
      compare_field("servo_id", 32'(got.servo_id), 32'(want.servo_id));
      compare_field("angle", 32'(got.angle), 32'(want.angle));
      compare_field("range_min", 32'(got.range_min), 32'(want.range_min));
      compare_field("range_max", 32'(got.range_max), 32'(want.range_max));
      compare_field("speed_report", 32'(got.speed_report), 32'(want.speed_report));
      compare_field("last", 32'(got.last), 32'(want.last));
    endtask
  endclass

endpackage

module tb_servo_command_slew_controller_top;
  import scsc_pkg::*;
  import servo_tb_pkg::*;

  localparam int CYCLE_LIMIT     = 1000000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 20;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  in_item_t    req       = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  out_item_t   rsp;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  servo_scoreboard sb;
  int cycle_count   = 0;
  int items_sent    = 0;
  bit req_gaps_on   = 1'b0;
  bit rsp_stalls_on = 1'b0;
  bit hold_off_req  = 1'b0;

  servo_command_slew_controller_top dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_result(rsp);
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        rsp_stall <= 1'b0;
      end else if (rsp_stalls_on && $urandom_range(0, 5) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input in_item_t it);
    if (req_gaps_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    req       <= it;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_input(it);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    in_item_t it;
    it.req_type   = 1'b0;
    it.byte_value = b;
    send_item(it);
  endtask

  task automatic send_tick();
    in_item_t it;
    it.req_type   = 1'b1;
    it.byte_value = 8'($urandom);
    send_item(it);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_tick();
  endtask

  task automatic send_end();
    send_byte($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
  endtask

  task automatic send_line(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
    send_end();
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (sb.awaited_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_interval(value[9:0]);
  endtask

  function automatic string servo_line();
    int         id;
    int         v;
    logic [7:0] b;
    string      s;
    id = $urandom_range(0, SERVOS - 1);
    s  = $sformatf("%c", ($urandom_range(0, 1) ? CHAR_A : CHAR_LC_A) + 8'(id));
    repeat ($urandom_range(0, 2)) begin
      case ($urandom_range(0, 3))
        0:       b = CHAR_SPACE;
        1:       b = CHAR_TAB;
        2:       b = CHAR_VT;
        default: b = CHAR_FF;
      endcase
      s = $sformatf("%s%c", s, b);
    end
    case ($urandom_range(0, 5))
      0:       s = $sformatf("%s-", s);
      1:       s = $sformatf("%s+", s);
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0:       v = $urandom_range(0, 180);
      1:       v = $urandom_range(181, 99999);
      2:       v = SAFE_MIN[id];
      3:       v = SAFE_MAX[id];
      default: v = $urandom_range(SAFE_MIN[id], SAFE_MAX[id]);
    endcase
    if ($urandom_range(0, 7) == 0) s = $sformatf("%s%05d", s, v);
    else s = $sformatf("%s%0d", s, v);
    case ($urandom_range(0, 11))
      0:       s = $sformatf("%s 9", s);
      1:       s = $sformatf("%sx", s);
      default: ;
    endcase
    return s;
  endfunction

  task automatic send_odd_line();
    logic [7:0] letter;
    letter = CHAR_A + 8'($urandom_range(0, SERVOS - 1));
    case ($urandom_range(0, 6))
      0: begin
        send_byte(CHAR_NUL);
        send_byte(letter);
        send_byte(CHAR_ZERO + 8'd5);
      end
      1: begin
        send_byte(letter);
        send_byte(CHAR_NUL);
        send_byte(CHAR_ZERO + 8'd9);
        send_byte(CHAR_ZERO);
      end
      2: begin
        send_byte(letter);
        send_byte(CHAR_ZERO + 8'($urandom_range(1, 9)));
        send_byte(CHAR_NUL);
        send_byte(CHAR_ZERO + 8'd7);
      end
      3: send_byte(letter);
      4: begin
        send_byte(letter);
        repeat ($urandom_range(1, 3)) send_byte(CHAR_SPACE);
      end
      5: begin
        send_byte(letter);
        send_byte($urandom_range(0, 1) ? CHAR_MINUS : CHAR_PLUS);
      end
      default: ;
    endcase
    send_end();
  endtask

  task automatic send_long_line();
    int n;
    n = $urandom_range(LINE_MAX + 1, LINE_MAX + 9);
    send_byte(CHAR_A + 8'($urandom_range(0, SERVOS - 1)));
    repeat (n - 1) begin
      send_byte(($urandom_range(0, 5) == 0) ? CHAR_SPACE : CHAR_ZERO + 8'($urandom_range(0, 9)));
    end
    send_end();
  endtask

  task automatic run_mix(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: begin
          send_line(servo_line());
          send_ticks($urandom_range(1, 30));
        end
        8, 9: begin
          case ($urandom_range(0, 3))
            0:       send_line("?");
            1:       send_line("h");
            2:       send_line("H");
            default: send_line("?ab");
          endcase
        end
        10, 11: begin
          case ($urandom_range(0, 2))
            0:       send_line("G");
            1:       send_line("g");
            default: send_line("g 5");
          endcase
        end
        12, 13: begin
          repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
          send_end();
        end
        14:      send_long_line();
        15, 16:  send_odd_line();
        default: send_ticks($urandom_range(1, 40));
      endcase
    end
  endtask

  initial begin
    logic [7:0] c_now;
    int         c_goal;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    req_gaps_on   = 1'b1;
    rsp_stalls_on = 1'b1;
    send_line("?");
    send_line("g");
    send_line("A12");
    send_line("b-5");
    send_line("Z");
    send_line("A");
    send_byte(CHAR_CR);
    send_ticks(2);

    settle();
    write_reg(REG_STEP_INTERVAL, 32'd0);
    while (sb.servo_moving()) send_tick();

    settle();
    write_reg(REG_STEP_INTERVAL, 32'd3);
    c_now  = sb.angle_of(2);
    c_goal = (c_now <= 8'd40) ? int'(c_now) + 9 : int'(c_now) - 9;
    send_line($sformatf("C%0d", c_goal));
    while (sb.servo_moving()) send_tick();
    send_tick();

    settle();
    write_reg(REG_STEP_INTERVAL, 32'd0);
    run_mix(70);

    settle();
    write_reg(REG_STEP_INTERVAL, 32'd1000);
    run_mix(40);

    settle();
    write_reg(REG_STEP_INTERVAL, 32'd7);
    hold_off_req = 1'b1;
    repeat (12) send_line("?");
    run_mix(40);

    settle();
    write_reg(REG_STEP_INTERVAL, 32'($urandom_range(0, 15)));
    req_gaps_on   = 1'b0;
    rsp_stalls_on = 1'b0;
    run_mix(40);

    settle();
    write_reg(REG_STEP_INTERVAL, 32'd1);
    run_mix(40);

    settle();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/scsc_pkg.sv
hw/rtl/scsc_core.sv
hw/rtl/scsc_expand.sv
hw/rtl/servo_command_slew_controller_top.sv
sim/tb_servo_command_slew_controller_top.sv
